// File: src/p2p_ie_pkg.sv
`timescale 1ns / 1ps

package p2p_ie_pkg;

   // Element and OUI constants of the P2P vendor element
   localparam logic [7:0] VENDOR_EID = 8'd221;
   localparam logic [7:0] OUI_BYTE0  = 8'h50;
   localparam logic [7:0] OUI_BYTE1  = 8'h6F;
   localparam logic [7:0] OUI_BYTE2  = 8'h9A;
   localparam logic [7:0] OUI_TYPE   = 8'h09;

   // Parse phases
   localparam logic [1:0] PH_SCAN    = 2'd0;
   localparam logic [1:0] PH_ATTR    = 2'd1;
   localparam logic [1:0] PH_CONTENT = 2'd2;
   localparam logic [1:0] PH_DONE    = 2'd3;

   // Status codes of the final record
   localparam logic [2:0] ST_FOUND      = 3'd0;
   localparam logic [2:0] ST_NO_ELEMENT = 3'd1;
   localparam logic [2:0] ST_ABSENT     = 3'd2;
   localparam logic [2:0] ST_SCAN_LIMIT = 3'd3;
   localparam logic [2:0] ST_TRUNCATED  = 3'd4;

   // Result kinds
   localparam logic KIND_CONTENT = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Output queue geometry
   localparam int RQ_DEPTH = 4;
   localparam int RQ_AW    = 2;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] content_byte;
      logic [2:0] status;
      logic [7:0] content_length;
      logic [9:0] element_offset;
      logic       last_result;
   } result_type;

   // Results produced by one accepted byte: 0, 1 or 2 of them, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// File: src/p2p_ie_if.sv
`timescale 1ns / 1ps

interface p2p_ie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface p2p_ie_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] content_byte;
   logic [2:0] status;
   logic [7:0] content_length;
   logic [9:0] element_offset;
   logic       last_result;

   modport source (output valid, output result_kind, output content_byte, output status,
                   output content_length, output element_offset, output last_result,
                   input ready);
   modport sink (input valid, input result_kind, input content_byte, input status,
                 input content_length, input element_offset, input last_result,
                 output ready);
endinterface

// File: src/p2p_ie_parser.sv
`timescale 1ns / 1ps

module p2p_ie_parser #(
   parameter int MAX_LIST_BYTES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  logic                 in_fire,
   input  logic [7:0]           in_data,
   input  logic                 in_last,
   output p2p_ie_pkg::push_type push
);
   import p2p_ie_pkg::*;

   // Positions stay below MAX_LIST_BYTES plus one element and its header
   localparam int PW = $clog2(MAX_LIST_BYTES + 264);
   localparam logic [PW-1:0] LIMIT = PW'(MAX_LIST_BYTES);

   logic [7:0]    target_id_ff;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] nes_ff, nes_in;
   logic [1:0]    phase_ff, phase_in;
   logic [39:0]   recent_ff, recent_in;
   logic [PW-1:0] elem_start_ff, elem_start_in;
   logic [8:0]    elem_len_ff, elem_len_in;
   logic [8:0]    attr_start_ff, attr_start_in;
   logic [7:0]    hdr_id_ff, hdr_id_in;
   logic [7:0]    hdr_lenlo_ff, hdr_lenlo_in;
   logic [7:0]    remaining_ff, remaining_in;
   logic          matched_ff, matched_in;
   logic [7:0]    match_len_ff, match_len_in;
   logic [2:0]    final_st_ff, final_st_in;

   logic [PW-1:0] rel_pos;
   logic [PW-1:0] hdr_idx;
   logic [15:0]   dlen;
   logic [16:0]   attr_end;
   logic [9:0]    skip_start;
   logic          emit_content;
   logic [2:0]    run_status;
   logic [PW+9:0] offset_ext;
   result_type    content_rec;
   result_type    status_rec;

   // Target attribute id register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_id_ff <= '0;
      end else if (csr_wr_en) begin
         target_id_ff <= csr_wr_data;
      end
   end

   // Next-state logic for one byte
   always_comb begin
      pos_in        = pos_ff;
      nes_in        = nes_ff;
      phase_in      = phase_ff;
      recent_in     = recent_ff;
      elem_start_in = elem_start_ff;
      elem_len_in   = elem_len_ff;
      attr_start_in = attr_start_ff;
      hdr_id_in     = hdr_id_ff;
      hdr_lenlo_in  = hdr_lenlo_ff;
      remaining_in  = remaining_ff;
      matched_in    = matched_ff;
      match_len_in  = match_len_ff;
      final_st_in   = final_st_ff;
      emit_content  = 1'b0;
      rel_pos       = pos_ff - elem_start_ff;
      hdr_idx       = rel_pos - PW'(attr_start_ff);
      dlen          = {in_data, hdr_lenlo_ff};
      attr_end      = 17'(attr_start_ff) + 17'd3 + 17'(dlen);
      skip_start    = 10'(attr_start_ff) + 10'd3 + 10'(dlen[8:0]);
      run_status    = ST_NO_ELEMENT;
      offset_ext    = '0;
      content_rec   = '0;
      status_rec    = '0;
      push          = '0;

      if (in_fire) begin
         if (phase_ff != PH_DONE) begin
            recent_in = {recent_ff[31:0], in_data};
            pos_in    = pos_ff + 1'b1;
            unique case (phase_ff)
               PH_SCAN: begin
                  // Judge an element once its sixth byte arrives
                  if (pos_ff == nes_ff + PW'(5)) begin
                     if (pos_ff >= LIMIT) begin
                        phase_in    = PH_DONE;
                        final_st_in = ST_SCAN_LIMIT;
                     end else if (recent_ff[39:32] == VENDOR_EID &&
                                  recent_ff[23:16] == OUI_BYTE0 &&
                                  recent_ff[15:8] == OUI_BYTE1 &&
                                  recent_ff[7:0] == OUI_BYTE2 &&
                                  in_data == OUI_TYPE) begin
                        elem_start_in = nes_ff;
                        elem_len_in   = 9'(recent_ff[31:24]) + 9'd2;
                        attr_start_in = 9'd6;
                        // no room for a whole attribute header
                        if (recent_ff[31:24] < 8'd7) begin
                           phase_in    = PH_DONE;
                           final_st_in = ST_ABSENT;
                        end else begin
                           phase_in = PH_ATTR;
                        end
                     end else begin
                        nes_in = nes_ff + PW'(recent_ff[31:24]) + PW'(2);
                     end
                  end
               end
               PH_ATTR: begin
                  // Collect the three header bytes of the current attribute
                  if (rel_pos >= PW'(attr_start_ff) && hdr_idx <= PW'(2)) begin
                     if (hdr_idx == PW'(0)) begin
                        hdr_id_in = in_data;
                     end else if (hdr_idx == PW'(1)) begin
                        hdr_lenlo_in = in_data;
                     end else begin
                        if (attr_end > 17'(elem_len_ff)) begin
                           phase_in    = PH_DONE;
                           final_st_in = ST_ABSENT;
                        end else if (hdr_id_ff == target_id_ff) begin
                           matched_in   = 1'b1;
                           match_len_in = dlen[7:0];
                           remaining_in = dlen[7:0];
                           if (dlen == 16'd0) begin
                              phase_in    = PH_DONE;
                              final_st_in = ST_FOUND;
                           end else begin
                              phase_in = PH_CONTENT;
                           end
                        end else begin
                           attr_start_in = skip_start[8:0];
                           if (skip_start + 10'd3 > 10'(elem_len_ff)) begin
                              phase_in    = PH_DONE;
                              final_st_in = ST_ABSENT;
                           end
                        end
                     end
                  end
               end
               PH_CONTENT: begin
                  emit_content = 1'b1;
                  if (remaining_ff != 8'd0) begin
                     remaining_in = remaining_ff - 1'b1;
                  end
                  if (remaining_ff <= 8'd1) begin
                     phase_in    = PH_DONE;
                     final_st_in = ST_FOUND;
                  end
               end
               default: begin
               end
            endcase
         end

         // Result records use the state as left by this byte
         offset_ext                 = (PW+10)'(elem_start_in);
         content_rec.result_kind    = KIND_CONTENT;
         content_rec.content_byte   = in_data;
         content_rec.status         = ST_FOUND;
         content_rec.content_length = matched_in ? match_len_in : 8'd0;
         content_rec.element_offset = (elem_len_in != 9'd0) ? offset_ext[9:0] : 10'd0;
         content_rec.last_result    = 1'b0;

         priority if (phase_in == PH_DONE) begin
            run_status = final_st_in;
         end else if (phase_in == PH_SCAN) begin
            run_status = ST_NO_ELEMENT;
         end else begin
            run_status = ST_TRUNCATED;
         end
         status_rec                = content_rec;
         status_rec.result_kind    = KIND_STATUS;
         status_rec.content_byte   = 8'd0;
         status_rec.status         = run_status;
         status_rec.last_result    = 1'b1;

         if (emit_content) begin
            push.first  = content_rec;
            push.second = status_rec;
            push.count  = in_last ? 2'd2 : 2'd1;
         end else begin
            push.first  = status_rec;
            push.second = status_rec;
            push.count  = in_last ? 2'd1 : 2'd0;
         end

         // End of list: start over on a fresh one
         if (in_last) begin
            pos_in        = '0;
            nes_in        = '0;
            phase_in      = PH_SCAN;
            recent_in     = '0;
            elem_start_in = '0;
            elem_len_in   = '0;
            attr_start_in = '0;
            hdr_id_in     = '0;
            hdr_lenlo_in  = '0;
            remaining_in  = '0;
            matched_in    = 1'b0;
            match_len_in  = '0;
            final_st_in   = ST_NO_ELEMENT;
         end
      end
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         nes_ff        <= '0;
         phase_ff      <= PH_SCAN;
         recent_ff     <= '0;
         elem_start_ff <= '0;
         elem_len_ff   <= '0;
         attr_start_ff <= '0;
         hdr_id_ff     <= '0;
         hdr_lenlo_ff  <= '0;
         remaining_ff  <= '0;
         matched_ff    <= 1'b0;
         match_len_ff  <= '0;
         final_st_ff   <= ST_NO_ELEMENT;
      end else begin
         pos_ff        <= pos_in;
         nes_ff        <= nes_in;
         phase_ff      <= phase_in;
         recent_ff     <= recent_in;
         elem_start_ff <= elem_start_in;
         elem_len_ff   <= elem_len_in;
         attr_start_ff <= attr_start_in;
         hdr_id_ff     <= hdr_id_in;
         hdr_lenlo_ff  <= hdr_lenlo_in;
         remaining_ff  <= remaining_in;
         matched_ff    <= matched_in;
         match_len_ff  <= match_len_in;
         final_st_ff   <= final_st_in;
      end
   end

endmodule

// File: src/p2p_ie_result_queue.sv
`timescale 1ns / 1ps

module p2p_ie_result_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  p2p_ie_pkg::push_type   push,
   output logic                   has_room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output p2p_ie_pkg::result_type out_rec
);
   import p2p_ie_pkg::*;

   result_type           entry_ff [RQ_DEPTH];
   logic [RQ_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [RQ_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RQ_AW:0]       count_ff, count_in;
   logic                 pop;

   // Room for the two results a byte can cause
   assign has_room  = count_ff <= (RQ_AW+1)'(RQ_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_rec   = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RQ_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + RQ_AW'(pop);
      count_in  = count_ff + (RQ_AW+1)'(push.count) - (RQ_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, up to two writes per cycle
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 1'b1] <= push.second;
      end
   end

endmodule

// File: src/p2p_ie_attribute_extractor_top.sv
`timescale 1ns / 1ps

// P2P attribute extractor. Takes one byte of an information-element list per
// cycle on req_ch and finds the first vendor element carrying the P2P OUI; the
// content bytes of the first attribute whose id equals the value written on
// csr_wr_data are sent on rsp_ch, one result per cycle, and the byte flagged
// last_byte is followed by a status record. Each byte is handled in the cycle
// it is accepted and its results are registered in a four-entry output queue
// before they are offered on rsp_ch; req_ch.ready holds high while the queue
// has room for two results. A byte can cause both a content result and the
// status record; one byte per cycle is sustained as long as rsp_ch is drained.
// Write csr_wr_data only while the block is idle.
module p2p_ie_attribute_extractor_top #(
   parameter int MAX_LIST_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   p2p_ie_req_if.sink  req_ch,
   p2p_ie_rsp_if.source rsp_ch
);
   import p2p_ie_pkg::*;

   push_type   push;
   result_type out_rec;
   logic       has_room;
   logic       in_fire;

   assign req_ch.ready = has_room;
   assign in_fire      = req_ch.valid && has_room;

   // Byte parser
   p2p_ie_parser #(
      .MAX_LIST_BYTES(MAX_LIST_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_fire     (in_fire),
      .in_data     (req_ch.data_byte),
      .in_last     (req_ch.last_byte),
      .push        (push)
   );

   // Output queue
   p2p_ie_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_rec   (out_rec)
   );

   assign rsp_ch.result_kind    = out_rec.result_kind;
   assign rsp_ch.content_byte   = out_rec.content_byte;
   assign rsp_ch.status         = out_rec.status;
   assign rsp_ch.content_length = out_rec.content_length;
   assign rsp_ch.element_offset = out_rec.element_offset;
   assign rsp_ch.last_result    = out_rec.last_result;

endmodule

// File: sim/p2p_ie_attribute_extractor_top_tb.sv
`timescale 1ns / 1ps

module p2p_ie_attribute_extractor_top_tb;
   import p2p_ie_pkg::*;

   localparam int MAX_LIST_BYTES = 1024;
   localparam int STALL_LIMIT    = 2000;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   p2p_ie_req_if req_ch ();
   p2p_ie_rsp_if rsp_ch ();

   p2p_ie_attribute_extractor_top #(
      .MAX_LIST_BYTES(MAX_LIST_BYTES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Expected extraction results, oldest first
   result_type  extract_results_q[$];
   logic [7:0]  ie_list[$];
   int unsigned bytes_sent;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_left = 0;
   bit          gaps_on;

   // Parser state mirror
   logic [7:0]  target_id;
   int unsigned cur_pos;
   int unsigned next_elem_start;
   logic [1:0]  parse_phase;
   logic [47:0] recent_window;
   int unsigned p2p_start;
   int unsigned p2p_len;
   int unsigned attr_off;
   logic [23:0] attr_hdr;
   int unsigned bytes_left;
   bit          attr_hit;
   logic [2:0]  run_status;

   function automatic void clear_parse();
      cur_pos         = 0;
      next_elem_start = 0;
      parse_phase     = PH_SCAN;
      recent_window   = '0;
      p2p_start       = 0;
      p2p_len         = 0;
      attr_off        = 0;
      attr_hdr        = '0;
      bytes_left      = 0;
      attr_hit        = 1'b0;
      run_status      = ST_NO_ELEMENT;
   endfunction

   function automatic void conclude(logic [2:0] st);
      parse_phase = PH_DONE;
      run_status  = st;
   endfunction

   function automatic void expect_result(logic kind, logic [7:0] data, logic [2:0] st,
                                         logic fin);
      result_type r;
      r.result_kind    = kind;
      r.content_byte   = data;
      r.status         = st;
      r.content_length = attr_hit ? attr_hdr[15:8] : 8'd0;
      r.element_offset = (p2p_len != 0) ? p2p_start[9:0] : 10'd0;
      r.last_result    = fin;
      extract_results_q.push_back(r);
   endfunction

   // Advance the parser mirror by one accepted byte
   function automatic void parse_ie_byte(logic [7:0] d, logic lst);
      int unsigned rel;
      int unsigned idx;
      int unsigned dlen;
      logic [2:0]  st;
      if (parse_phase != PH_DONE) begin
         recent_window = {recent_window[39:0], d};
         if (parse_phase == PH_SCAN) begin
            // element header plus OUI complete
            if (cur_pos == next_elem_start + 5) begin
               if (cur_pos >= MAX_LIST_BYTES) begin
                  conclude(ST_SCAN_LIMIT);
               end else if (recent_window[47:40] == VENDOR_EID &&
                            recent_window[31:24] == OUI_BYTE0 &&
                            recent_window[23:16] == OUI_BYTE1 &&
                            recent_window[15:8] == OUI_BYTE2 &&
                            recent_window[7:0] == OUI_TYPE) begin
                  p2p_start = next_elem_start;
                  p2p_len   = 32'(recent_window[39:32]) + 2;
                  attr_off  = 6;
                  if (p2p_len <= 6 || attr_off + 3 > p2p_len)
                     conclude(ST_ABSENT);
                  else
                     parse_phase = PH_ATTR;
               end else begin
                  next_elem_start += 32'(recent_window[39:32]) + 2;
               end
            end
         end else if (parse_phase == PH_ATTR) begin
            rel = cur_pos - p2p_start;
            if (rel >= attr_off && rel <= attr_off + 2) begin
               idx = rel - attr_off;
               if (idx == 0)
                  attr_hdr = '0;
               attr_hdr |= 24'(d) << (8 * idx);
               if (idx == 2) begin
                  dlen = 32'(attr_hdr[23:8]);
                  if (attr_off + 3 + dlen > p2p_len) begin
                     conclude(ST_ABSENT);
                  end else if (attr_hdr[7:0] == target_id) begin
                     attr_hit   = 1'b1;
                     bytes_left = dlen;
                     if (dlen == 0)
                        conclude(ST_FOUND);
                     else
                        parse_phase = PH_CONTENT;
                  end else begin
                     attr_off += 3 + dlen;
                     if (attr_off + 3 > p2p_len)
                        conclude(ST_ABSENT);
                  end
               end
            end
         end else begin
            expect_result(KIND_CONTENT, d, ST_FOUND, 1'b0);
            if (bytes_left > 0)
               bytes_left--;
            if (bytes_left == 0)
               conclude(ST_FOUND);
         end
         cur_pos++;
      end

      // status record closes the list
      if (lst) begin
         if (parse_phase == PH_DONE)
            st = run_status;
         else if (parse_phase == PH_SCAN)
            st = ST_NO_ELEMENT;
         else
            st = ST_TRUNCATED;
         expect_result(KIND_STATUS, 8'd0, st, 1'b1);
         clear_parse();
      end
   endfunction

   // One byte transfer; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] d, input logic lst);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.data_byte = d;
      req_ch.last_byte = lst;
      do @(posedge clock); while (!req_ch.ready);
      parse_ie_byte(d, lst);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_ie_list();
      foreach (ie_list[i])
         send_byte(ie_list[i], i == ie_list.size() - 1);
   endtask

   task automatic wait_results_drained();
      req_ch.valid = 1'b0;
      while (extract_results_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_target_id(input logic [7:0] value);
      wait_results_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      target_id = value;
   endtask

   // Non-P2P element; some are vendor elements with a wrong OUI type
   function automatic void add_plain_element();
      logic [7:0] id;
      logic [7:0] blen;
      logic [7:0] body[$];
      id   = 8'($urandom_range(0, 255));
      blen = 8'($urandom_range(0, 12));
      for (int i = 0; i < blen; i++)
         body.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0 && blen >= 4) begin
         id      = VENDOR_EID;
         body[0] = OUI_BYTE0;
         body[1] = OUI_BYTE1;
         body[2] = OUI_BYTE2;
         body[3] = OUI_TYPE ^ 8'($urandom_range(1, 255));
      end
      ie_list.push_back(id);
      ie_list.push_back(blen);
      foreach (body[i])
         ie_list.push_back(body[i]);
   endfunction

   function automatic void add_filler_element(input logic [7:0] blen);
      ie_list.push_back(8'h30);
      ie_list.push_back(blen);
      repeat (blen) ie_list.push_back(8'($urandom_range(0, 255)));
   endfunction

   // P2P element with a random attribute walk, some lengths broken
   function automatic void add_p2p_element();
      logic [7:0]  body[$];
      int unsigned clen;
      int unsigned flen;
      repeat ($urandom_range(0, 4)) begin
         clen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
         flen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : clen;
         body.push_back(($urandom_range(0, 2) == 0) ? target_id : 8'($urandom_range(0, 255)));
         body.push_back(flen[7:0]);
         body.push_back(flen[15:8]);
         repeat (clen) body.push_back(8'($urandom_range(0, 255)));
      end
      // padding too short for another attribute header
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) body.push_back(8'($urandom_range(0, 255)));
      while (body.size() > 251)
         void'(body.pop_back());
      ie_list.push_back(VENDOR_EID);
      ie_list.push_back(8'(body.size() + 4));
      ie_list.push_back(OUI_BYTE0);
      ie_list.push_back(OUI_BYTE1);
      ie_list.push_back(OUI_BYTE2);
      ie_list.push_back(OUI_TYPE);
      foreach (body[i])
         ie_list.push_back(body[i]);
   endfunction

   // P2P element whose declared length leaves little or no attribute room
   function automatic void add_short_p2p_element();
      logic [7:0] blen;
      logic [7:0] oui[4];
      oui  = '{OUI_BYTE0, OUI_BYTE1, OUI_BYTE2, OUI_TYPE};
      blen = 8'($urandom_range(0, 9));
      ie_list.push_back(VENDOR_EID);
      ie_list.push_back(blen);
      for (int i = 0; i < blen; i++)
         ie_list.push_back((i < 4) ? oui[i] : 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 6)) ie_list.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_random_list();
      int unsigned pick;
      int unsigned keep;
      ie_list.delete();
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         repeat ($urandom_range(0, 3)) add_plain_element();
         if ($urandom_range(0, 3) != 0)
            add_p2p_element();
         repeat ($urandom_range(0, 2)) add_plain_element();
         // cut the list short now and then
         if ($urandom_range(0, 5) == 0 && ie_list.size() > 0) begin
            keep = $urandom_range(1, ie_list.size());
            while (ie_list.size() > keep)
               void'(ie_list.pop_back());
         end
      end else if (pick < 17) begin
         add_short_p2p_element();
      end else begin
         repeat ($urandom_range(1, 40)) ie_list.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 0)
            ie_list[0] = VENDOR_EID;
      end
      if (ie_list.size() == 0)
         ie_list.push_back(8'($urandom_range(0, 255)));
      send_ie_list();
   endtask

   // Every status code but the scan limit, and the two-result byte, target id at its reset value
   task automatic test_directed();
      ie_list = '{8'hFF};
      send_ie_list();
      // zero-length match: found at once
      ie_list = '{8'hDD, 8'h07, 8'h50, 8'h6F, 8'h9A, 8'h09, 8'h00, 8'h00, 8'h00};
      send_ie_list();
      // one content byte on the final byte: content and status together
      ie_list = '{8'hDD, 8'h09, 8'h50, 8'h6F, 8'h9A, 8'h09, 8'h00, 8'h01, 8'h00, 8'hFF};
      send_ie_list();
      // element too short for any attribute
      ie_list = '{8'hDD, 8'h04, 8'h50, 8'h6F, 8'h9A, 8'h09};
      send_ie_list();
      // list ends during the attribute walk
      ie_list = '{8'hDD, 8'h07, 8'h50, 8'h6F, 8'h9A, 8'h09, 8'h00};
      send_ie_list();
   endtask

   // Element judged just past the scan limit
   task automatic test_scan_limit();
      write_target_id(8'h0C);
      ie_list.delete();
      repeat (3) add_filler_element(8'd253);
      add_filler_element(8'd252);
      ie_list = {ie_list, 8'hDD, 8'h07, 8'h50, 8'h6F, 8'h9A, 8'h09, 8'h0C, 8'h01, 8'h00,
                 8'h5A};
      send_ie_list();
   endtask

   // Random lists over several target ids, the last phase without gaps
   task automatic test_random_lists();
      logic [7:0]  ids[4];
      int unsigned start;
      ids = '{8'hFF, 8'($urandom_range(0, 255)), 8'h00, 8'($urandom_range(0, 255))};
      for (int p = 0; p < 4; p++) begin
         write_target_id(ids[p]);
         gaps_on = (p != 3);
         start   = bytes_sent;
         while (bytes_sent - start < 190)
            send_random_list();
      end
   endtask

   // Result ready with random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready = 1'b0;
         stall_left   = $urandom_range(0, 8);
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Result checker and watchdog
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (extract_results_q.size() == 0) begin
               $display("%0t: result expected none, got kind %0h byte %0h status %0h",
                        $time, rsp_ch.result_kind, rsp_ch.content_byte, rsp_ch.status);
               mismatch_count++;
            end else begin
               want = extract_results_q.pop_front();
               report_field("result_kind", 32'(want.result_kind),
                            32'(rsp_ch.result_kind));
               report_field("content_byte", 32'(want.content_byte),
                            32'(rsp_ch.content_byte));
               report_field("status", 32'(want.status), 32'(rsp_ch.status));
               report_field("content_length", 32'(want.content_length),
                            32'(rsp_ch.content_length));
               report_field("element_offset", 32'(want.element_offset),
                            32'(rsp_ch.element_offset));
               report_field("last_result", 32'(want.last_result),
                            32'(rsp_ch.last_result));
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 8'd0;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'd0;
      req_ch.last_byte = 1'b0;
      gaps_on          = 1'b1;
      bytes_sent       = 0;
      target_id        = 8'd0;
      clear_parse();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_scan_limit();
      test_random_lists();

      wait_results_drained();
      repeat (6) @(negedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
src/p2p_ie_pkg.sv
src/p2p_ie_if.sv
src/p2p_ie_parser.sv
src/p2p_ie_result_queue.sv
src/p2p_ie_attribute_extractor_top.sv
sim/p2p_ie_attribute_extractor_top_tb.sv
